// ===== rtl/core/spmm_pkg.sv =====
package spmm_pkg;

  // Fixed field and accumulator widths.
  localparam int SUM_W  = 40;
  localparam int MUL_AW = 43;
  localparam int MUL_BW = 18;
  localparam int PROD_W = MUL_AW + MUL_BW;

  // Command codes of an input transaction.
  localparam logic CMD_CHANNEL = 1'b0;
  localparam logic CMD_MASTER  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_MASTER = 3'd4;
  localparam logic [2:0] REG_MODE   = 3'd5;
  localparam logic [31:0] SETTING_RESET = 32'd16384;

  // Gain limits in Q2.14.
  localparam logic [14:0] CH_GAIN_TOP = 15'd24576;
  localparam logic [14:0] MS_GAIN_TOP = 15'd16384;

  // Meter scale: 20*log10(2)/40 * 2^10 * 2^16.
  localparam logic [23:0] METER_K = 24'd10100891;
  localparam logic [10:0] LEVEL_FULL = 11'd1024;

  // Output clamp at +-10 V.
  localparam logic signed [15:0] OUT_MAX = 16'sd32767;

  // Operations issued by the controller to the datapath.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_GAIN_MUL,
    OP_GAIN_SET,
    OP_PAN,
    OP_SQ_MUL,
    OP_SQ_SET,
    OP_COS_MUL,
    OP_COS_SUB,
    OP_W_SET,
    OP_V_MUL,
    OP_V_SET,
    OP_CH_MUL,
    OP_CH_ADD,
    OP_MONO_MUL,
    OP_ACC_MUL1,
    OP_ACC_LD,
    OP_ACC_MUL2,
    OP_ACC_ADD,
    OP_LV_MUL,
    OP_OUT_SET,
    OP_MTR_INIT,
    OP_MTR_MUL,
    OP_MTR_STEP,
    OP_MTR_KMUL,
    OP_MTR_FIN,
    OP_CLEAR,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] step;
    logic       sel;
    logic       load;
  } ctl_t;

  typedef struct packed {
    logic master;
    logic mono;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic               command;
    logic [1:0]         channel;
    logic signed [15:0] sample;
    logic signed [15:0] gain_cv;
    logic               gain_cv_present;
    logic signed [15:0] pan_cv;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [10:0]        level_a;
    logic [10:0]        level_b;
    logic               frame_done;
  } result_t;

  // Coefficients of the quarter-cosine polynomial, Horner order.
  function automatic logic [16:0] cos_coef(input logic [1:0] step);
    logic [16:0] c;
    case (step)
      2'd0:    c = 17'd1367;
      2'd1:    c = 17'd16625;
      2'd2:    c = 17'd80852;
      default: c = 17'd65536;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/spmm_in_if.sv =====
interface spmm_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [1:0]        channel;
  logic signed [15:0] sample;
  logic signed [15:0] gain_cv;
  logic              gain_cv_present;
  logic signed [15:0] pan_cv;

  modport source(output valid, command, channel, sample, gain_cv, gain_cv_present, pan_cv,
                 input ready);
  modport sink(input valid, command, channel, sample, gain_cv, gain_cv_present, pan_cv,
               output ready);
endinterface

// ===== rtl/core/spmm_out_if.sv =====
interface spmm_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic [10:0]       level_a;
  logic [10:0]       level_b;
  logic              frame_done;

  modport source(output valid, out_left, out_right, level_a, level_b, frame_done,
                 input ready);
  modport sink(input valid, out_left, out_right, level_a, level_b, frame_done,
               output ready);
endinterface

// ===== rtl/core/spmm_cfg_if.sv =====
interface spmm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/spmm_ctrl.sv =====
module spmm_ctrl #(
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spmm_pkg::sts_t   sts,
  output spmm_pkg::ctl_t   ctl
);

  localparam int CW = $clog2(LOG_TABLE_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_GAIN_MUL, S_GAIN_SET, S_PAN, S_SQ_MUL, S_SQ_SET, S_COS_MUL, S_COS_SUB,
    S_W_SET, S_V_MUL, S_V_SET, S_CH_MUL, S_CH_ADD, S_MONO_MUL, S_ACC_MUL1, S_ACC_LD,
    S_ACC_MUL2, S_ACC_ADD, S_LV_MUL, S_OUT_SET, S_MTR_INIT, S_MTR_MUL, S_MTR_STEP,
    S_MTR_KMUL, S_MTR_FIN, S_CLEAR, S_EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          sel;

  assign in_ready = (state == S_IDLE);

  // Operation decode from the current state.
  always_comb begin
    ctl.step = cnt[1:0];
    ctl.sel  = sel;
    ctl.load = in_valid && (state == S_IDLE);
    unique case (state)
      S_IDLE:     ctl.op = spmm_pkg::OP_NOP;
      S_GAIN_MUL: ctl.op = spmm_pkg::OP_GAIN_MUL;
      S_GAIN_SET: ctl.op = spmm_pkg::OP_GAIN_SET;
      S_PAN:      ctl.op = spmm_pkg::OP_PAN;
      S_SQ_MUL:   ctl.op = spmm_pkg::OP_SQ_MUL;
      S_SQ_SET:   ctl.op = spmm_pkg::OP_SQ_SET;
      S_COS_MUL:  ctl.op = spmm_pkg::OP_COS_MUL;
      S_COS_SUB:  ctl.op = spmm_pkg::OP_COS_SUB;
      S_W_SET:    ctl.op = spmm_pkg::OP_W_SET;
      S_V_MUL:    ctl.op = spmm_pkg::OP_V_MUL;
      S_V_SET:    ctl.op = spmm_pkg::OP_V_SET;
      S_CH_MUL:   ctl.op = spmm_pkg::OP_CH_MUL;
      S_CH_ADD:   ctl.op = spmm_pkg::OP_CH_ADD;
      S_MONO_MUL: ctl.op = spmm_pkg::OP_MONO_MUL;
      S_ACC_MUL1: ctl.op = spmm_pkg::OP_ACC_MUL1;
      S_ACC_LD:   ctl.op = spmm_pkg::OP_ACC_LD;
      S_ACC_MUL2: ctl.op = spmm_pkg::OP_ACC_MUL2;
      S_ACC_ADD:  ctl.op = spmm_pkg::OP_ACC_ADD;
      S_LV_MUL:   ctl.op = spmm_pkg::OP_LV_MUL;
      S_OUT_SET:  ctl.op = spmm_pkg::OP_OUT_SET;
      S_MTR_INIT: ctl.op = spmm_pkg::OP_MTR_INIT;
      S_MTR_MUL:  ctl.op = spmm_pkg::OP_MTR_MUL;
      S_MTR_STEP: ctl.op = spmm_pkg::OP_MTR_STEP;
      S_MTR_KMUL: ctl.op = spmm_pkg::OP_MTR_KMUL;
      S_MTR_FIN:  ctl.op = spmm_pkg::OP_MTR_FIN;
      S_CLEAR:    ctl.op = spmm_pkg::OP_CLEAR;
      S_EMIT:     ctl.op = spmm_pkg::OP_EMIT;
      default:    ctl.op = spmm_pkg::OP_NOP;
    endcase
  end

  // Sequencer: gain, two pan weights, accumulate or mix, meters, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      sel   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          sel <= 1'b0;
          if (in_valid) state <= S_GAIN_MUL;
        end
        S_GAIN_MUL: state <= S_GAIN_SET;
        S_GAIN_SET: state <= S_PAN;
        S_PAN: begin
          sel   <= 1'b0;
          state <= S_SQ_MUL;
        end
        S_SQ_MUL: state <= S_SQ_SET;
        S_SQ_SET: begin
          cnt   <= '0;
          state <= S_COS_MUL;
        end
        S_COS_MUL: state <= S_COS_SUB;
        S_COS_SUB: begin
          if (cnt == CW'(3)) begin
            state <= S_W_SET;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_COS_MUL;
          end
        end
        S_W_SET: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_SQ_MUL;
          end else begin
            sel <= 1'b0;
            if (sts.master != spmm_pkg::CMD_MASTER) state <= S_V_MUL;
            else if (sts.mono) state <= S_MONO_MUL;
            else state <= S_ACC_MUL1;
          end
        end
        S_V_MUL: state <= S_V_SET;
        S_V_SET: state <= S_CH_MUL;
        S_CH_MUL: state <= S_CH_ADD;
        S_CH_ADD: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_CH_MUL;
          end else begin
            sel   <= 1'b0;
            state <= S_MTR_INIT;
          end
        end
        S_MONO_MUL: state <= S_OUT_SET;
        S_ACC_MUL1: state <= S_ACC_LD;
        S_ACC_LD:   state <= S_ACC_MUL2;
        S_ACC_MUL2: state <= S_ACC_ADD;
        S_ACC_ADD:  state <= S_LV_MUL;
        S_LV_MUL:   state <= S_OUT_SET;
        S_OUT_SET: begin
          if (sts.mono || sel) begin
            sel   <= 1'b0;
            state <= S_MTR_INIT;
          end else begin
            sel   <= 1'b1;
            state <= S_ACC_MUL1;
          end
        end
        S_MTR_INIT: begin
          cnt   <= '0;
          state <= S_MTR_MUL;
        end
        S_MTR_MUL: state <= S_MTR_STEP;
        S_MTR_STEP: begin
          if (cnt == CW'(LOG_TABLE_BITS - 1)) begin
            state <= S_MTR_KMUL;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_MTR_MUL;
          end
        end
        S_MTR_KMUL: state <= S_MTR_FIN;
        S_MTR_FIN: begin
          if (sts.master != spmm_pkg::CMD_MASTER) begin
            state <= S_EMIT;
          end else if (!sel) begin
            sel   <= 1'b1;
            state <= S_MTR_INIT;
          end else begin
            state <= S_CLEAR;
          end
        end
        S_CLEAR: state <= S_EMIT;
        S_EMIT: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/spmm_dpath.sv =====
module spmm_dpath #(
  parameter int PAN_TABLE_BITS = 8,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  spmm_pkg::item_t     item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  spmm_pkg::ctl_t      ctl,
  output spmm_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output spmm_pkg::result_t   res
);

  localparam int SW   = spmm_pkg::SUM_W;
  localparam int PW   = spmm_pkg::PROD_W;
  localparam int PSH  = 15 - PAN_TABLE_BITS;
  localparam int USH  = 16 - PAN_TABLE_BITS;
  localparam int KSH  = LOG_TABLE_BITS + 16;
  localparam int LTB  = LOG_TABLE_BITS;
  localparam logic signed [SW:0] SUM_MAX = (SW+1)'(64'sd549755813887);
  localparam logic signed [SW:0] SUM_MIN = -(SW+1)'(64'sd549755813888);

  // Configuration and the latched transaction.
  logic [31:0]        set_reg [5];
  logic               mode;
  spmm_pkg::item_t    itm;
  logic [31:0]        set_sel;

  // Working registers.
  logic [14:0]        g;
  logic [16:0]        uc, ub, u2, r, wa, wb;
  logic signed [30:0] v;
  logic [15:0]        mval;
  logic signed [SW-1:0] left_sum, right_sum, mono_sum;
  logic signed [PW-1:0] acc;
  logic signed [41:0] lv;
  logic signed [15:0] lout, rout;
  logic [16:0]        x;
  logic [LTB-1:0]     frac;
  logic [3:0]         ex;
  logic               mz, mf;
  logic [10:0]        lvla, lvlb;

  // Shared multiplier.
  logic signed [spmm_pkg::MUL_AW-1:0] ma;
  logic signed [spmm_pkg::MUL_BW-1:0] mb;
  logic signed [PW-1:0] prod;

  // Combinational helpers.
  logic signed [PW-1:0] gq, oval, av;
  logic signed [PW:0]   tsum;
  logic signed [19:0]   pv;
  logic [15:0]          pk;
  logic [16:0]          uval;
  logic [15:0]          msrc;
  logic [3:0]           elead;
  logic [16:0]          xs;
  logic [LTB+3:0]       dval;
  logic [PW-1-KSH:0]    subw;
  logic [14:0]          gtop;
  logic [16:0]          wsel_a, wsel_b;

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] s,
                                                   input logic signed [SW:0] a);
    logic signed [SW+1:0] t;
    t = (SW+2)'(s) + (SW+2)'(a);
    if (t > (SW+2)'(SUM_MAX)) return SW'(SUM_MAX);
    if (t < (SW+2)'(SUM_MIN)) return SW'(SUM_MIN);
    return SW'(t);
  endfunction

  assign set_sel = (itm.command == spmm_pkg::CMD_MASTER) ? set_reg[spmm_pkg::REG_MASTER]
                                                          : set_reg[{1'b0, itm.channel}];
  assign gtop    = (itm.command == spmm_pkg::CMD_MASTER) ? spmm_pkg::MS_GAIN_TOP
                                                          : spmm_pkg::CH_GAIN_TOP;
  assign wsel_a  = ctl.sel ? wb : wa;
  assign wsel_b  = ctl.sel ? wa : wb;

  // Multiplier operand selection.
  always_comb begin
    case (ctl.op)
      spmm_pkg::OP_GAIN_MUL: begin
        ma = spmm_pkg::MUL_AW'(itm.gain_cv);
        mb = spmm_pkg::MUL_BW'(set_sel[15:0]);
      end
      spmm_pkg::OP_SQ_MUL: begin
        ma = spmm_pkg::MUL_AW'(uc);
        mb = spmm_pkg::MUL_BW'(uc);
      end
      spmm_pkg::OP_COS_MUL: begin
        ma = spmm_pkg::MUL_AW'(u2);
        mb = spmm_pkg::MUL_BW'(r);
      end
      spmm_pkg::OP_V_MUL: begin
        ma = spmm_pkg::MUL_AW'(itm.sample);
        mb = spmm_pkg::MUL_BW'(g);
      end
      spmm_pkg::OP_CH_MUL: begin
        ma = spmm_pkg::MUL_AW'(v);
        mb = spmm_pkg::MUL_BW'(ctl.sel ? wb : wa);
      end
      spmm_pkg::OP_MONO_MUL: begin
        ma = spmm_pkg::MUL_AW'(mono_sum);
        mb = spmm_pkg::MUL_BW'(g);
      end
      spmm_pkg::OP_ACC_MUL1: begin
        ma = spmm_pkg::MUL_AW'(left_sum);
        mb = spmm_pkg::MUL_BW'(wsel_a);
      end
      spmm_pkg::OP_ACC_MUL2: begin
        ma = spmm_pkg::MUL_AW'(right_sum);
        mb = spmm_pkg::MUL_BW'(wsel_b);
      end
      spmm_pkg::OP_LV_MUL: begin
        ma = spmm_pkg::MUL_AW'(lv);
        mb = spmm_pkg::MUL_BW'(g);
      end
      spmm_pkg::OP_MTR_MUL: begin
        ma = spmm_pkg::MUL_AW'(x);
        mb = spmm_pkg::MUL_BW'(x);
      end
      spmm_pkg::OP_MTR_KMUL: begin
        ma = spmm_pkg::MUL_AW'(spmm_pkg::METER_K);
        mb = spmm_pkg::MUL_BW'(dval);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Arithmetic on the registered product and the meter front end.
  always_comb begin
    gq   = prod >>> 15;
    oval = prod >>> 28;
    av   = prod[PW-1] ? -prod : prod;
    tsum = (PW+1)'(acc) + (PW+1)'(prod);
    pv   = 20'($signed(set_sel[31:16])) + (20'(itm.pan_cv) <<< 2) + 20'(itm.pan_cv);
    if (pv < -20'sd16384) pk = 16'd0;
    else if (pv > 20'sd16384) pk = 16'd32768;
    else pk = 16'(pv + 20'sd16384);
    uval = 17'(pk >> PSH) << USH;
    if (itm.command != spmm_pkg::CMD_MASTER) msrc = mval;
    else if (ctl.sel) msrc = 16'(rout[15] ? -rout : rout);
    else msrc = 16'(lout[15] ? -lout : lout);
    elead = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (msrc[i]) elead = 4'(i);
    end
    xs   = prod[31:15];
    dval = {4'd15 - ex, {LTB{1'b0}}} - (LTB+4)'(frac);
    subw = prod[PW-1:KSH];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (ctl.load) begin
      itm <= item;
    end
    case (ctl.op)
      spmm_pkg::OP_GAIN_SET: begin
        if (itm.gain_cv_present) begin
          if (gq[PW-1]) g <= '0;
          else if (gq[PW-2:0] > (PW-1)'(gtop)) g <= gtop;
          else g <= 15'(gq);
        end else begin
          g <= (set_sel[15:0] > 16'(gtop)) ? gtop : set_sel[14:0];
        end
      end
      spmm_pkg::OP_PAN: begin
        uc <= uval;
        ub <= 17'd65536 - uval;
      end
      spmm_pkg::OP_SQ_SET: begin
        u2 <= prod[32:16];
        r  <= 17'd60;
      end
      spmm_pkg::OP_COS_SUB: r <= spmm_pkg::cos_coef(ctl.step) - prod[32:16];
      spmm_pkg::OP_W_SET: begin
        if (!ctl.sel) begin
          wa <= r;
          uc <= ub;
        end else begin
          wb <= r;
        end
      end
      spmm_pkg::OP_V_SET: begin
        v    <= prod[30:0];
        mval <= av[29:14];
      end
      spmm_pkg::OP_ACC_LD: acc <= prod;
      spmm_pkg::OP_ACC_ADD: lv <= 42'(tsum >>> 16);
      spmm_pkg::OP_OUT_SET: begin
        if (ctl.sel) begin
          if (oval < -(PW'(spmm_pkg::OUT_MAX))) rout <= -spmm_pkg::OUT_MAX;
          else if (oval > PW'(spmm_pkg::OUT_MAX)) rout <= spmm_pkg::OUT_MAX;
          else rout <= 16'(oval);
        end else begin
          if (oval < -(PW'(spmm_pkg::OUT_MAX))) lout <= -spmm_pkg::OUT_MAX;
          else if (oval > PW'(spmm_pkg::OUT_MAX)) lout <= spmm_pkg::OUT_MAX;
          else lout <= 16'(oval);
          if (mode) rout <= '0;
        end
      end
      spmm_pkg::OP_MTR_INIT: begin
        mz   <= (msrc == 16'd0);
        mf   <= (msrc >= 16'd32767);
        ex   <= elead;
        x    <= 17'({16'd0, msrc} << (4'd15 - elead));
        frac <= '0;
      end
      spmm_pkg::OP_MTR_STEP: begin
        frac <= {frac[LTB-2:0], xs[16]};
        x    <= xs[16] ? {1'b0, xs[16:1]} : xs;
      end
      spmm_pkg::OP_MTR_FIN: begin
        if (ctl.sel) begin
          if (mz) lvlb <= '0;
          else if (mf) lvlb <= spmm_pkg::LEVEL_FULL;
          else if (subw >= (PW-KSH)'(1024)) lvlb <= '0;
          else lvlb <= spmm_pkg::LEVEL_FULL - 11'(subw);
        end else begin
          if (mz) lvla <= '0;
          else if (mf) lvla <= spmm_pkg::LEVEL_FULL;
          else if (subw >= (PW-KSH)'(1024)) lvla <= '0;
          else lvla <= spmm_pkg::LEVEL_FULL - 11'(subw);
        end
      end
      default: ;
    endcase
    if (ctl.op == spmm_pkg::OP_EMIT && !(out_valid && !out_ready)) begin
      res.out_left   <= (itm.command == spmm_pkg::CMD_MASTER) ? lout : '0;
      res.out_right  <= (itm.command == spmm_pkg::CMD_MASTER) ? rout : '0;
      res.level_a    <= lvla;
      res.level_b    <= (itm.command == spmm_pkg::CMD_MASTER) ? lvlb : '0;
      res.frame_done <= itm.command;
    end
  end

  // Sums, configuration and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) set_reg[i] <= spmm_pkg::SETTING_RESET;
      mode      <= 1'b0;
      left_sum  <= '0;
      right_sum <= '0;
      mono_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < spmm_pkg::REG_MODE) set_reg[cfg_index] <= cfg_data;
        else if (cfg_index == spmm_pkg::REG_MODE) mode <= cfg_data[0];
      end
      case (ctl.op)
        spmm_pkg::OP_V_SET: mono_sum <= sat_add(mono_sum, (SW+1)'($signed(prod[30:0])));
        spmm_pkg::OP_CH_ADD: begin
          if (ctl.sel) right_sum <= sat_add(right_sum, (SW+1)'(prod >>> 16));
          else left_sum <= sat_add(left_sum, (SW+1)'(prod >>> 16));
        end
        spmm_pkg::OP_CLEAR: begin
          left_sum  <= '0;
          right_sum <= '0;
          mono_sum  <= '0;
        end
        default: ;
      endcase
      if (ctl.op == spmm_pkg::OP_EMIT && !(out_valid && !out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  assign sts.master   = itm.command;
  assign sts.mono     = mode;
  assign sts.out_busy = out_valid && !out_ready;

endmodule

// ===== rtl/core/stereo_pan_mixer_with_meter.sv =====
// Four-channel constant-power pan mixer with log bar meters.
// All multiplications of a transaction share one 43x18 multiplier.
// One transaction is worked at a time; the result register frees the input side.
// Synchronous reset restores unity gain, center pan, stereo mode and clears the sums.
module stereo_pan_mixer_with_meter #(
  parameter int PAN_TABLE_BITS = 8,
  parameter int LOG_TABLE_BITS = 6
) (
  input logic         clk,
  input logic         rst,
  spmm_in_if.sink     in_ch,
  spmm_out_if.source  out_ch,
  spmm_cfg_if.sink    cfg
);

  spmm_pkg::ctl_t    ctl;
  spmm_pkg::sts_t    sts;
  spmm_pkg::item_t   item;
  spmm_pkg::result_t res;
  logic              in_ready;
  logic              out_valid;

  // Gather the input payload.
  assign item.command         = in_ch.command;
  assign item.channel         = in_ch.channel;
  assign item.sample          = in_ch.sample;
  assign item.gain_cv         = in_ch.gain_cv;
  assign item.gain_cv_present = in_ch.gain_cv_present;
  assign item.pan_cv          = in_ch.pan_cv;
  assign in_ch.ready          = in_ready;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  spmm_ctrl #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  spmm_dpath #(
    .PAN_TABLE_BITS(PAN_TABLE_BITS),
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  // Drive the result channel.
  assign out_ch.valid      = out_valid;
  assign out_ch.out_left   = res.out_left;
  assign out_ch.out_right  = res.out_right;
  assign out_ch.level_a    = res.level_a;
  assign out_ch.level_b    = res.level_b;
  assign out_ch.frame_done = res.frame_done;

endmodule
